// ===== design/gtpu_pkg.sv =====
// ----------------------------------------------------------------------------
// GTP-U encapsulator package
// Shared constants, codes and types for the buffered GTP-U encapsulator.
// ----------------------------------------------------------------------------
package gtpu_pkg;

    // Number of timestamp bytes at the head of every stored buffer (0 to 15).
    localparam int TS_BYTES = 8;
    localparam int SKIP_W   = 4;

    // Depth of the command queue between the front and the back end.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // GTP-U header constants.
    localparam logic [7:0] GTP_FLAGS = 8'h30;
    localparam logic [7:0] GTP_TPDU  = 8'hFF;

    // Parser phases.
    localparam logic [1:0] PH_SKIP    = 2'd0;
    localparam logic [1:0] PH_LEN_LO  = 2'd1;
    localparam logic [1:0] PH_LEN_HI  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    // Command kinds passed from the front to the back end.
    localparam logic [1:0] CMD_HDR  = 2'd0;
    localparam logic [1:0] CMD_PAY  = 2'd1;
    localparam logic [1:0] CMD_MARK = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W  = 1;
    localparam logic [0:0] CFG_ENABLE = 1'b0;
    localparam logic [0:0] CFG_TEID   = 1'b1;

    // One command: a header (data holds the length), a payload byte
    // (data[7:0] holds the byte) or a truncation marker.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic        pend;
        logic        trunc;
    } t_cmd;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== design/gtpu_fifo.sv =====
// ----------------------------------------------------------------------------
// GTP-U command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module gtpu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gtpu_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output gtpu_pkg::t_cmd o_cmd,
    output gtpu_pkg::t_q_stat o_stat
);
    import gtpu_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_cmd        = r_mem[r_rptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/gtpu_front.sv =====
// ----------------------------------------------------------------------------
// GTP-U front end
// Accepts buffer bytes, tracks the framing and queues at most one command per byte.
// ----------------------------------------------------------------------------
module gtpu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_enable,
    input  gtpu_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output gtpu_pkg::t_cmd    o_cmd
);
    import gtpu_pkg::*;

    logic [1:0]        r_phase, n_phase;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [7:0]        r_len_lo, n_len_lo;
    logic [15:0]       r_left, n_left;

    logic        accept;
    logic [1:0]  eff_phase;
    logic [15:0] len;
    logic [15:0] left_dec;

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign len        = {i_data_byte, r_len_lo};
    assign left_dec   = r_left - 16'd1;

    // With no timestamp bytes the first byte is already the length low byte.
    assign eff_phase = (r_phase == PH_SKIP && TS_BYTES == 0) ? PH_LEN_LO : r_phase;

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_len_lo = r_len_lo;
        n_left   = r_left;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (accept) begin
            if (!i_enable) begin
                n_phase  = PH_SKIP;
                n_skip   = '0;
                n_len_lo = '0;
                n_left   = '0;
            end else begin
                unique case (eff_phase)
                    PH_SKIP: begin
                        n_skip = r_skip + 1'b1;
                        if (n_skip == SKIP_W'(TS_BYTES)) begin
                            n_phase = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO: begin
                        n_len_lo = i_data_byte;
                        n_phase  = PH_LEN_HI;
                        if (i_last_byte) begin
                            o_push      = 1'b1;
                            o_cmd.kind  = CMD_MARK;
                            o_cmd.trunc = 1'b1;
                        end
                    end
                    PH_LEN_HI: begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_HDR;
                        o_cmd.data  = len;
                        o_cmd.trunc = i_last_byte && (len != 16'd0);
                        n_left      = len;
                        n_phase     = (len == 16'd0) ? PH_LEN_LO : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        o_push      = 1'b1;
                        o_cmd.kind  = CMD_PAY;
                        o_cmd.data  = {8'd0, i_data_byte};
                        o_cmd.pend  = (left_dec == 16'd0);
                        o_cmd.trunc = i_last_byte && (left_dec != 16'd0);
                        n_left      = left_dec;
                        n_phase     = (left_dec == 16'd0) ? PH_LEN_LO : PH_PAYLOAD;
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase
                if (i_last_byte) begin
                    n_phase  = PH_SKIP;
                    n_skip   = '0;
                    n_len_lo = '0;
                    n_left   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_skip   <= '0;
            r_len_lo <= '0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_len_lo <= n_len_lo;
            r_left   <= n_left;
        end
    end

endmodule

// ===== design/gtpu_back.sv =====
// ----------------------------------------------------------------------------
// GTP-U back end
// Expands queued commands into output bytes behind a registered output stage.
// ----------------------------------------------------------------------------
module gtpu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtpu_pkg::t_cmd    i_cmd,
    input  gtpu_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    input  logic [31:0]       i_teid,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_packet_end,
    output logic              o_run_end,
    output logic              o_truncated
);
    import gtpu_pkg::*;

    logic       r_busy, n_busy;
    t_cmd       r_cmd;
    logic [2:0] r_idx, n_idx;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_obyte;
    logic       r_opend, r_orun, r_otrunc;

    logic       load;
    logic       last_of_cmd;
    logic [7:0] cur_byte;
    logic       cur_pend;

    assign load        = !r_ovalid || !i_out_stall;
    assign last_of_cmd = (r_cmd.kind != CMD_HDR) || (r_idx == 3'd7);

    always_comb begin
        cur_byte = '0;
        cur_pend = 1'b0;
        unique case (r_cmd.kind)
            CMD_HDR: begin
                cur_pend = (r_idx == 3'd7) && (r_cmd.data == 16'd0);
                unique case (r_idx)
                    3'd0: cur_byte = GTP_FLAGS;
                    3'd1: cur_byte = GTP_TPDU;
                    3'd2: cur_byte = r_cmd.data[15:8];
                    3'd3: cur_byte = r_cmd.data[7:0];
                    3'd4: cur_byte = i_teid[31:24];
                    3'd5: cur_byte = i_teid[23:16];
                    3'd6: cur_byte = i_teid[15:8];
                    default: cur_byte = i_teid[7:0];
                endcase
            end
            CMD_PAY: begin
                cur_byte = r_cmd.data[7:0];
                cur_pend = r_cmd.pend;
            end
            default: begin
                cur_byte = '0;
                cur_pend = 1'b0;
            end
        endcase
    end

    // A new command is taken when nothing is in work or the current one
    // hands over its last byte in this cycle.
    assign o_pop = !i_q_stat.empty && (!r_busy || (load && last_of_cmd));

    always_comb begin
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        if (load) begin
            n_ovalid = r_busy;
        end
        if (r_busy && load) begin
            if (last_of_cmd) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (load && r_busy) begin
            r_obyte  <= cur_byte;
            r_opend  <= cur_pend;
            r_orun   <= last_of_cmd;
            r_otrunc <= last_of_cmd && r_cmd.trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_packet_end = r_opend;
    assign o_run_end    = r_orun;
    assign o_truncated  = r_otrunc;

endmodule

// ===== design/gtpu_buffered_packet_encapsulator.sv =====
// Path: an accepted byte passes the command queue, the back end's command register and
// the output register before its first output byte shows. Flow: one input byte per cycle
// while the queue is not full; one output byte per cycle while not stalled; a length high
// byte expands to eight header bytes, buffered by the four-entry queue and byte counter.
// Reset: synchronous, active low; clears the framing state, the queue, the output
// valid and both configuration registers (encapsulation off, tunnel id zero).
// ----------------------------------------------------------------------------
// GTP-U buffered packet encapsulator
// Turns a stored length-prefixed packet buffer into GTP-U v1 framed packets.
// ----------------------------------------------------------------------------
module gtpu_buffered_packet_encapsulator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input byte channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_byte,
    // Output byte channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_out_byte,
    output logic                               o_packet_end,
    output logic                               o_run_end,
    output logic                               o_truncated,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gtpu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import gtpu_pkg::*;

    // Configuration registers. A write request is always taken; o_cfg_ready is tied high.
    // Writes must arrive only while the block is idle; the block does not enforce this, and
    // the back end reads the tunnel id straight from its register when it builds a header.
    logic        r_enable;
    logic [31:0] r_teid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_teid   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_TEID:   r_teid   <= i_cfg_data;
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // The front end classifies each buffer byte (timestamp, length low,
    // length high, payload) and queues at most one command for it.
    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    gtpu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_enable    (r_enable),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // The queue lets the front keep taking payload bytes while the back end
    // is still emitting a header or waiting on a stalled output.
    gtpu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // The back end walks a header command through its eight bytes and passes each payload
    // and marker command as a single byte, into a registered output stage.
    gtpu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_cmd),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .i_teid       (r_teid),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_end    (o_run_end),
        .o_truncated  (o_truncated)
    );

endmodule

// ===== design/gtpu_checker.sv =====
// ----------------------------------------------------------------------------
// GTP-U encapsulator checker
// Port-level assertions on the encapsulator, attached by bind.
// ----------------------------------------------------------------------------
module gtpu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_packet_end,
    input logic       o_run_end,
    input logic       o_truncated
);

    // A stalled output request keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_packet_end))
        else $error("output request changed while stalled");

    // A packet always ends on the last byte produced for one input byte.
    a_pend_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |-> o_run_end)
        else $error("packet end without run end");

    // Truncation is only flagged on the last byte of a run.
    a_trunc_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_run_end)
        else $error("truncation without run end");

    // A finished packet is never also a truncated one.
    a_pend_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_packet_end && o_truncated))
        else $error("packet end and truncation together");

endmodule

bind gtpu_buffered_packet_encapsulator gtpu_checker u_gtpu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_byte   (o_out_byte),
    .o_packet_end (o_packet_end),
    .o_run_end    (o_run_end),
    .o_truncated  (o_truncated)
);
